FILE: design/bgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Button gesture detector package
// Shared types, register indexes and constants for the gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

   localparam int unsigned ELAPSED_W = 17;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
   localparam logic [ELAPSED_W-1:0] XLONG_EXTRA_TICKS = 17'd4000;

   localparam logic [15:0] HOLD_WAIT_RESET       = 16'd1000;
   localparam logic [15:0] DOUBLE_WAIT_RESET     = 16'd250;
   localparam logic        UNPRESSED_LEVEL_RESET = 1'b1;

   // Bit positions of the gesture flags.
   localparam int unsigned FLAG_TAP    = 0;
   localparam int unsigned FLAG_DOUBLE = 1;
   localparam int unsigned FLAG_LONG   = 2;
   localparam int unsigned FLAG_XLONG  = 3;

   typedef enum logic [1:0] {
      CSR_HOLD_WAIT       = 2'd0,
      CSR_DOUBLE_WAIT     = 2'd1,
      CSR_UNPRESSED_LEVEL = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [15:0] hold_wait;
      logic [15:0] double_wait;
      logic        unpressed_level;
   } cfg_type;

   typedef struct packed {
      logic ack_xlong;
      logic ack_long;
      logic ack_double;
      logic ack_tap;
      logic switch_level;
   } tick_type;

   typedef struct packed {
      logic xlong_pending;
      logic long_pending;
      logic double_pending;
      logic tap_pending;
      logic is_pressed;
   } result_type;

endpackage
`default_nettype wire

FILE: design/bgd_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gesture detector core
// Holds the press state and elapsed counters and classifies each tick.
// ----------------------------------------------------------------------------
module bgd_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire bgd_pkg::cfg_type    cfg,
   input  wire bgd_pkg::tick_type   tick,
   output bgd_pkg::result_type      result
);

   // The pressed flag always equals the previous active level, so one
   // register serves both.
   logic                         pressed_ff, pressed_in;
   logic                         first_tap_ff, first_tap_in;
   logic [3:0]                   flags_ff, flags_in;
   logic                         check_long_ff, check_long_in;
   logic                         check_xlong_ff, check_xlong_in;
   logic                         check_double_ff, check_double_in;
   logic [bgd_pkg::ELAPSED_W-1:0] hold_ff, hold_in;
   logic [bgd_pkg::ELAPSED_W-1:0] release_ff, release_in;

   logic                          active;
   logic                          early_clear;
   logic                          any_clear;
   logic                          xlong_clear;
   logic [bgd_pkg::ELAPSED_W-1:0] hold_limit;
   logic [bgd_pkg::ELAPSED_W-1:0] xlong_limit;

   assign active = tick.switch_level != cfg.unpressed_level;
   assign hold_limit = {1'b0, cfg.hold_wait};
   assign xlong_limit = hold_limit + bgd_pkg::XLONG_EXTRA_TICKS;

   // Once any acknowledge clears the flags, later acknowledges see nothing.
   assign early_clear = (tick.ack_tap    && flags_ff[bgd_pkg::FLAG_TAP])
                     || (tick.ack_double && flags_ff[bgd_pkg::FLAG_DOUBLE])
                     || (tick.ack_long   && flags_ff[bgd_pkg::FLAG_LONG]);
   assign xlong_clear = !early_clear && tick.ack_xlong && flags_ff[bgd_pkg::FLAG_XLONG];
   assign any_clear = early_clear || xlong_clear;

   always_comb begin
      first_tap_in    = first_tap_ff && !any_clear;
      flags_in        = any_clear ? 4'b0000 : flags_ff;
      check_long_in   = check_long_ff && !any_clear;
      check_double_in = check_double_ff && !any_clear;
      check_xlong_in  = check_xlong_ff && !xlong_clear;
      pressed_in      = active;
      hold_in    = (hold_ff == bgd_pkg::ELAPSED_MAX) ? hold_ff : hold_ff + 1'b1;
      release_in = (release_ff == bgd_pkg::ELAPSED_MAX) ? release_ff : release_ff + 1'b1;

      if (active && !pressed_ff) begin
         check_long_in = 1'b1;
         hold_in       = '0;
         if (first_tap_in) begin
            flags_in[bgd_pkg::FLAG_DOUBLE] = 1'b1;
            first_tap_in    = 1'b0;
            check_double_in = 1'b0;
            check_long_in   = 1'b0;
         end else begin
            first_tap_in = 1'b1;
         end
      end else if (!active && pressed_ff) begin
         check_long_in  = 1'b0;
         check_xlong_in = 1'b0;
         if (first_tap_in && (cfg.double_wait != 16'd0)) begin
            check_double_in = 1'b1;
            release_in      = '0;
         end
      end else if (active) begin
         if (check_xlong_in && (hold_in > xlong_limit)) begin
            flags_in[bgd_pkg::FLAG_XLONG] = 1'b1;
         end else if (check_long_in && (hold_in > hold_limit)) begin
            flags_in[bgd_pkg::FLAG_LONG] = 1'b1;
            check_long_in  = 1'b0;
            first_tap_in   = 1'b0;
            check_xlong_in = 1'b1;
         end
      end else if (check_double_in && first_tap_in
                   && (release_in > {1'b0, cfg.double_wait})) begin
         first_tap_in    = 1'b0;
         check_double_in = 1'b0;
         flags_in[bgd_pkg::FLAG_TAP] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff      <= 1'b0;
         first_tap_ff    <= 1'b0;
         flags_ff        <= 4'b0000;
         check_long_ff   <= 1'b0;
         check_xlong_ff  <= 1'b0;
         check_double_ff <= 1'b0;
         hold_ff         <= '0;
         release_ff      <= '0;
      end else if (step) begin
         pressed_ff      <= pressed_in;
         first_tap_ff    <= first_tap_in;
         flags_ff        <= flags_in;
         check_long_ff   <= check_long_in;
         check_xlong_ff  <= check_xlong_in;
         check_double_ff <= check_double_in;
         hold_ff         <= hold_in;
         release_ff      <= release_in;
      end
   end

   assign result.is_pressed     = pressed_in;
   assign result.tap_pending    = flags_in[bgd_pkg::FLAG_TAP];
   assign result.double_pending = flags_in[bgd_pkg::FLAG_DOUBLE];
   assign result.long_pending   = flags_in[bgd_pkg::FLAG_LONG];
   assign result.xlong_pending  = flags_in[bgd_pkg::FLAG_XLONG];

endmodule
`default_nettype wire

FILE: design/button_gesture_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// The result of an accepted request is held in the result register and shown in the cycle after acceptance.
// Throughput: one request per cycle while the result side is not stalled, set by the single result register stage.
// The request side stays ready while the result register is empty or being drained.
// Reset (synchronous, active high) clears the press state, counters and flags,
// empties the result register and restores hold 1000, double 250, released level 1.
// ----------------------------------------------------------------------------
// Button gesture detector
// Classifies millisecond ticks of a switch level into tap, double tap,
// long hold and extra-long hold with acknowledge-cleared pending flags.
// ----------------------------------------------------------------------------
module button_gesture_detector (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream: one millisecond tick per request.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // Fields from bit 0: switch_level, ack_tap, ack_double, ack_long, ack_xlong, zeros.
   input  wire logic [7:0]  req_tdata,
   // Result stream: one result per request.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // Fields from bit 0: is_pressed, tap_pending, double_pending, long_pending,
   // xlong_pending, zeros.
   output logic [7:0]       rsp_tdata,
   // Configuration writes.
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);

   bgd_pkg::cfg_type    cfg_ff;
   bgd_pkg::tick_type   tick;
   bgd_pkg::result_type result;
   logic                req_fire;
   logic                rsp_valid_ff;
   logic [7:0]          rsp_data_ff;

   // The result register parts the two sides: a new request is taken
   // whenever the register is empty or its content leaves in this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign tick       = bgd_pkg::tick_type'(req_tdata[4:0]);

   // Configuration registers; writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_wait       <= bgd_pkg::HOLD_WAIT_RESET;
         cfg_ff.double_wait     <= bgd_pkg::DOUBLE_WAIT_RESET;
         cfg_ff.unpressed_level <= bgd_pkg::UNPRESSED_LEVEL_RESET;
      end else if (csr_we) begin
         unique case (bgd_pkg::csr_index_type'(csr_addr))
            bgd_pkg::CSR_HOLD_WAIT:       cfg_ff.hold_wait       <= csr_wdata;
            bgd_pkg::CSR_DOUBLE_WAIT:     cfg_ff.double_wait     <= csr_wdata;
            bgd_pkg::CSR_UNPRESSED_LEVEL: cfg_ff.unpressed_level <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The core updates its state on every accepted request and presents
   // the result of that tick combinationally.
   bgd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (req_fire),
      .cfg    (cfg_ff),
      .tick   (tick),
      .result (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= {3'b000, result};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: design/bgd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gesture detector port checker
// Watches the request and result streams of the gesture detector.
// ----------------------------------------------------------------------------
module bgd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   // Every accepted request produces a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request gave no result");

   // The block never stalls requests while its result register is free.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("request stalled with free result register");

   // A result appears only after a request was accepted.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without request");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Padding bits of the result are zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:5] == 3'b000)
      else $error("result padding not zero");

endmodule

bind button_gesture_detector bgd_checker u_bgd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
